@@ rtl/core/csq_pkg.sv @@
`default_nettype none

package csq_pkg;

  // sizing
  localparam int MAX_WAITERS    = 16;
  localparam int THREAD_ID_BITS = 8;
  localparam int QPTR_W         = $clog2(MAX_WAITERS);
  localparam int QFILL_W        = $clog2(MAX_WAITERS + 1);
  localparam int COUNT_W        = 16;
  localparam int CMD_W          = 3;
  localparam int STATUS_W       = 3;
  localparam int TID_W          = 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN     = 3'd0,
    CMD_CLOSE    = 3'd1,
    CMD_WAIT     = 3'd2,
    CMD_SIGNAL   = 3'd3,
    CMD_TRY_WAIT = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_NOT_OPEN       = 3'd1,
    ST_ALREADY_CLOSED = 3'd2,
    ST_BLOCKED        = 3'd3,
    ST_NO_WAITER      = 3'd4,
    ST_WOULD_BLOCK    = 3'd5,
    ST_QUEUE_FULL     = 3'd6,
    ST_ALREADY_OPEN   = 3'd7
  } status_t;

  // request item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] thread_id;
  } req_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                woken_valid;
    logic [TID_W-1:0]    woken_thread;
    logic                woken_by_close;
    logic                last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // execute the request item this cycle
    logic drain;  // pop one waiter for close
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_open;
    logic q_empty;
    logic q_one;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/csq_ctrl.sv @@
`default_nettype none

module csq_ctrl import csq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic [CMD_W-1:0] req_cmd,
  output logic      req_stall,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t state;
  logic   accept;
  logic   start_drain;

  // handshake and commands
  always_comb begin
    req_stall   = (state == S_DRAIN) || !sts.out_free;
    accept      = req_valid && !req_stall;
    start_drain = accept && (req_cmd == CMD_CLOSE) && sts.is_open && !sts.q_empty;
    ctl.exec    = accept;
    ctl.drain   = (state == S_DRAIN) && sts.out_free;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start_drain) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (ctl.drain && sts.q_one) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // drain runs only on a closed semaphore with waiters left
  a_drain_closed: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !sts.is_open) else $error("drain while open");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !sts.q_empty) else $error("drain on empty queue");
  a_no_exec_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !ctl.exec) else $error("item taken during drain");

endmodule

`default_nettype wire

@@ rtl/core/csq_dpath.sv @@
`default_nettype none

module csq_dpath import csq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  input  wire logic [COUNT_W-1:0] cfg_data,
  input  wire req_t req,
  input  wire ctl_t ctl,
  output sts_t      sts,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam logic [QPTR_W-1:0]  PTR_LAST  = QPTR_W'(MAX_WAITERS - 1);
  localparam logic [QFILL_W-1:0] FILL_FULL = QFILL_W'(MAX_WAITERS);
  localparam logic [QFILL_W-1:0] FILL_ONE  = QFILL_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [COUNT_W-1:0]        initial_count;
  logic [COUNT_W-1:0]        count, count_next;
  logic                      is_open, is_open_next;
  logic [QPTR_W-1:0]         q_head, q_head_next;
  logic [QPTR_W-1:0]         q_tail, q_tail_next;
  logic [QFILL_W-1:0]        q_fill, q_fill_next;
  logic [THREAD_ID_BITS-1:0] q_mem [MAX_WAITERS];
  logic                      push;
  logic                      emit;
  logic [TID_W-1:0]          head_tid;
  rsp_t                      res;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == PTR_LAST) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_tid = TID_W'(q_mem[q_head]);

  // status to the controller
  always_comb begin
    sts.is_open  = is_open;
    sts.q_empty  = (q_fill == '0);
    sts.q_one    = (q_fill == FILL_ONE);
    sts.out_free = !rsp_valid || !rsp_stall;
  end

  // operation execute
  always_comb begin
    count_next   = count;
    is_open_next = is_open;
    q_head_next  = q_head;
    q_tail_next  = q_tail;
    q_fill_next  = q_fill;
    push         = 1'b0;
    emit         = 1'b0;
    res          = '0;
    res.status   = ST_OK;
    res.last     = 1'b1;
    if (ctl.exec) begin
      unique case (req.cmd)
        CMD_OPEN: begin
          emit = 1'b1;
          if (is_open) begin
            res.status = ST_ALREADY_OPEN;
          end else begin
            is_open_next = 1'b1;
            count_next   = initial_count;
            q_head_next  = '0;
            q_tail_next  = '0;
            q_fill_next  = '0;
          end
        end
        CMD_CLOSE: begin
          if (!is_open) begin
            emit       = 1'b1;
            res.status = ST_ALREADY_CLOSED;
          end else begin
            is_open_next = 1'b0;
            // waiters are released by the drain that follows
            emit = (q_fill == '0);
          end
        end
        CMD_WAIT: begin
          emit = 1'b1;
          if (!is_open) begin
            res.status = ST_NOT_OPEN;
          end else if (count != '0) begin
            count_next = count - COUNT_W'(1);
          end else if (q_fill == FILL_FULL) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            push        = 1'b1;
            q_tail_next = next_ptr(q_tail);
            q_fill_next = q_fill + QFILL_W'(1);
            res.status  = ST_BLOCKED;
          end
        end
        CMD_SIGNAL: begin
          emit = 1'b1;
          if (!is_open) begin
            res.status = ST_NOT_OPEN;
          end else if (q_fill != '0) begin
            q_head_next      = next_ptr(q_head);
            q_fill_next      = q_fill - QFILL_W'(1);
            res.woken_valid  = 1'b1;
            res.woken_thread = head_tid;
          end else begin
            if (count != COUNT_MAX) begin
              count_next = count + COUNT_W'(1);
            end
            res.status = ST_NO_WAITER;
          end
        end
        CMD_TRY_WAIT: begin
          emit = 1'b1;
          if (!is_open) begin
            res.status = ST_NOT_OPEN;
          end else if (count != '0) begin
            count_next = count - COUNT_W'(1);
          end else begin
            res.status = ST_WOULD_BLOCK;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (ctl.drain) begin
      emit               = 1'b1;
      res.woken_valid    = 1'b1;
      res.woken_thread   = head_tid;
      res.woken_by_close = 1'b1;
      res.last           = (q_fill == FILL_ONE);
      if (q_fill == FILL_ONE) begin
        q_head_next = '0;
        q_tail_next = '0;
        q_fill_next = '0;
      end else begin
        q_head_next = next_ptr(q_head);
        q_fill_next = q_fill - QFILL_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= '0;
      count         <= '0;
      is_open       <= 1'b0;
      q_head        <= '0;
      q_tail        <= '0;
      q_fill        <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        initial_count <= cfg_data;
      end
      count     <= count_next;
      is_open   <= is_open_next;
      q_head    <= q_head_next;
      q_tail    <= q_tail_next;
      q_fill    <= q_fill_next;
      rsp_valid <= emit || (rsp_valid && rsp_stall);
    end
  end

  // wait queue storage and result register
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_tail] <= THREAD_ID_BITS'(req.thread_id);
    end
    if (emit) begin
      rsp <= res;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_fill <= FILL_FULL) else $error("queue fill out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (q_fill == '0 || q_fill == FILL_FULL) == (q_head == q_tail))
    else $error("queue pointers disagree with fill");
  a_close_wakes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.woken_by_close |-> rsp.woken_valid && !is_open)
    else $error("close release without a woken thread");

endmodule

`default_nettype wire

@@ rtl/core/counting_semaphore_wait_queue_unit.sv @@
// results are registered; a close with waiters gives its first result via the drain state
// throughput: one item per cycle unless results stall; a close with n waiters gives n results,
// one per cycle from the single queue read port, stalling requests until all are out
// reset (synchronous): semaphore closed, count, initial_count and queue pointers zero,
// queue storage is not cleared
`default_nettype none

module counting_semaphore_wait_queue_unit import csq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  ctl_t ctl;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  csq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ tb/counting_semaphore_wait_queue_unit_test.sv @@
`timescale 1ns / 100ps

module counting_semaphore_wait_queue_unit_test;
  import csq_pkg::*;

  // reserved command codes, the block ignores them
  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_TOP  = 16'hFFFF;
  localparam int TARGET_ITEMS = 380;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  counting_semaphore_wait_queue_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // semaphore shadow state
  logic [COUNT_W-1:0] init_count_shadow = '0;
  logic [COUNT_W-1:0] sem_count = '0;
  logic               sem_open = 1'b0;
  logic [TID_W-1:0]   waiter_ring [MAX_WAITERS];
  int                 ring_head = 0;
  int                 ring_tail = 0;
  int                 ring_fill = 0;

  rsp_t wake_batch [$];
  rsp_t pending_rsp [$];

  // typed expectation riding along with the current item
  logic cur_typed = 1'b0;
  rsp_t cur_want = '0;

  int errors = 0;
  int rsp_seen = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int stall_len;

  // directed stimulus table
  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] value;
    logic [CMD_W-1:0]   cmd;
    logic [TID_W-1:0]   tid;
    bit                 typed;
    rsp_t               want;
  } plan_row_t;

  plan_row_t plan [$];

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic rsp_t mk_rsp(status_t s, logic wv, logic [TID_W-1:0] wt, logic wc,
                                  logic l);
    rsp_t r;
    r.status = s;
    r.woken_valid = wv;
    r.woken_thread = wt;
    r.woken_by_close = wc;
    r.last = l;
    return r;
  endfunction

  function automatic int next_ring(int p);
    return (p + 1 >= MAX_WAITERS) ? 0 : p + 1;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // semaphore behavior for one request, results go to wake_batch
  function automatic void predict_sem(req_t r);
    logic [TID_W-1:0] t;
    wake_batch.delete();
    case (r.cmd)
      CMD_OPEN: begin
        if (sem_open) begin
          wake_batch.push_back(mk_rsp(ST_ALREADY_OPEN, 0, '0, 0, 1));
        end else begin
          sem_open = 1'b1;
          sem_count = init_count_shadow;
          ring_head = 0;
          ring_tail = 0;
          ring_fill = 0;
          wake_batch.push_back(mk_rsp(ST_OK, 0, '0, 0, 1));
        end
      end
      CMD_CLOSE: begin
        if (!sem_open) begin
          wake_batch.push_back(mk_rsp(ST_ALREADY_CLOSED, 0, '0, 0, 1));
        end else begin
          sem_open = 1'b0;
          if (ring_fill == 0) begin
            wake_batch.push_back(mk_rsp(ST_OK, 0, '0, 0, 1));
          end
          // drain oldest first, last flag on the final waiter
          while (ring_fill > 0) begin
            t = waiter_ring[ring_head];
            ring_head = next_ring(ring_head);
            ring_fill--;
            wake_batch.push_back(mk_rsp(ST_OK, 1, t, 1, ring_fill == 0));
          end
          ring_head = 0;
          ring_tail = 0;
          ring_fill = 0;
        end
      end
      CMD_WAIT: begin
        if (!sem_open) begin
          wake_batch.push_back(mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
        end else if (sem_count != 0) begin
          sem_count = sem_count - 1'b1;
          wake_batch.push_back(mk_rsp(ST_OK, 0, '0, 0, 1));
        end else if (ring_fill >= MAX_WAITERS) begin
          wake_batch.push_back(mk_rsp(ST_QUEUE_FULL, 0, '0, 0, 1));
        end else begin
          waiter_ring[ring_tail] = r.thread_id;
          ring_tail = next_ring(ring_tail);
          ring_fill++;
          wake_batch.push_back(mk_rsp(ST_BLOCKED, 0, '0, 0, 1));
        end
      end
      CMD_SIGNAL: begin
        if (!sem_open) begin
          wake_batch.push_back(mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
        end else if (ring_fill > 0) begin
          t = waiter_ring[ring_head];
          ring_head = next_ring(ring_head);
          ring_fill--;
          wake_batch.push_back(mk_rsp(ST_OK, 1, t, 0, 1));
        end else begin
          if (sem_count != COUNT_TOP) sem_count = sem_count + 1'b1;
          wake_batch.push_back(mk_rsp(ST_NO_WAITER, 0, '0, 0, 1));
        end
      end
      CMD_TRY_WAIT: begin
        if (!sem_open) begin
          wake_batch.push_back(mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
        end else if (sem_count != 0) begin
          sem_count = sem_count - 1'b1;
          wake_batch.push_back(mk_rsp(ST_OK, 0, '0, 0, 1));
        end else begin
          wake_batch.push_back(mk_rsp(ST_WOULD_BLOCK, 0, '0, 0, 1));
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at result %0d, %s: got %0d want %0d", rsp_seen, what, got, want);
    errors++;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (quiet) begin
      rsp_stall <= 1'b0;
    end else begin
      stall_len = gap_len();
      if (stall_len > 0) begin
        stall_left = stall_len - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) init_count_shadow = cfg_data;
      if (req_valid && !req_stall) begin
        predict_sem(req);
        if (cur_typed) begin
          pending_rsp.push_back(cur_want);
        end else begin
          foreach (wake_batch[i]) pending_rsp.push_back(wake_batch[i]);
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("result with nothing pending", rsp, 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.woken_valid !== want.woken_valid)
            report_mismatch("woken_valid", rsp.woken_valid, want.woken_valid);
          if (rsp.woken_thread !== want.woken_thread)
            report_mismatch("woken_thread", rsp.woken_thread, want.woken_thread);
          if (rsp.woken_by_close !== want.woken_by_close)
            report_mismatch("woken_by_close", rsp.woken_by_close, want.woken_by_close);
          if (rsp.last !== want.last)
            report_mismatch("last", rsp.last, want.last);
        end
        rsp_seen++;
      end
    end
  end

  // one request item, with an optional gap in front
  task automatic send_item(logic [CMD_W-1:0] c, logic [TID_W-1:0] t, bit typed, rsp_t want);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.cmd <= c;
    req.thread_id <= t;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (!(req_valid && !req_stall));
    if (c <= CMD_TRY_WAIT) items_sent++;
  endtask

  // hold the request side until every pending result is out
  task automatic wait_idle();
    req_valid <= 1'b0;
    // let the monitor log the item taken at this edge first
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_item(logic [CMD_W-1:0] c, logic [TID_W-1:0] t);
    plan_row_t row;
    row.is_cfg = 0;
    row.value = '0;
    row.cmd = c;
    row.tid = t;
    row.typed = 0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(logic [CMD_W-1:0] c, logic [TID_W-1:0] t, rsp_t w);
    plan_row_t row;
    row.is_cfg = 0;
    row.value = '0;
    row.cmd = c;
    row.tid = t;
    row.typed = 1;
    row.want = w;
    plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic [COUNT_W-1:0] v);
    plan_row_t row;
    row.is_cfg = 1;
    row.value = v;
    row.cmd = '0;
    row.tid = '0;
    row.typed = 0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  // run limit
  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int shape;
    int len;
    int op;
    int burst;
    int phase;
    logic [COUNT_W-1:0] v;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // commands on a closed semaphore, reserved codes
    plan_typed(CMD_WAIT, 8'h00, mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
    plan_typed(CMD_SIGNAL, 8'hFF, mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
    plan_typed(CMD_TRY_WAIT, 8'h5A, mk_rsp(ST_NOT_OPEN, 0, '0, 0, 1));
    plan_typed(CMD_CLOSE, 8'h00, mk_rsp(ST_ALREADY_CLOSED, 0, '0, 0, 1));
    plan_item(CMD_RSVD_LO, 8'h00);
    plan_item(CMD_RSVD_HI, 8'hFF);
    // top count: saturating signal
    plan_cfg(COUNT_TOP);
    plan_typed(CMD_OPEN, 8'h00, mk_rsp(ST_OK, 0, '0, 0, 1));
    plan_typed(CMD_OPEN, 8'h00, mk_rsp(ST_ALREADY_OPEN, 0, '0, 0, 1));
    plan_typed(CMD_SIGNAL, 8'h00, mk_rsp(ST_NO_WAITER, 0, '0, 0, 1));
    plan_typed(CMD_TRY_WAIT, 8'h00, mk_rsp(ST_OK, 0, '0, 0, 1));
    plan_typed(CMD_WAIT, 8'hFF, mk_rsp(ST_OK, 0, '0, 0, 1));
    plan_typed(CMD_CLOSE, 8'h00, mk_rsp(ST_OK, 0, '0, 0, 1));
    // zero count: blocking, wake, close with waiters
    plan_cfg('0);
    plan_typed(CMD_OPEN, 8'hFF, mk_rsp(ST_OK, 0, '0, 0, 1));
    plan_typed(CMD_TRY_WAIT, 8'h00, mk_rsp(ST_WOULD_BLOCK, 0, '0, 0, 1));
    plan_typed(CMD_WAIT, 8'hFF, mk_rsp(ST_BLOCKED, 0, '0, 0, 1));
    plan_typed(CMD_WAIT, 8'h00, mk_rsp(ST_BLOCKED, 0, '0, 0, 1));
    plan_typed(CMD_SIGNAL, 8'h00, mk_rsp(ST_OK, 1, 8'hFF, 0, 1));
    plan_item(CMD_WAIT, 8'hA5);
    plan_item(CMD_RSVD_MID, 8'h3C);
    plan_item(CMD_CLOSE, 8'h00);
    plan_item(CMD_SIGNAL, 8'h11);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_count(plan[i].value);
      else send_item(plan[i].cmd, plan[i].tid, plan[i].typed, plan[i].want);
    end

    // random phases, each with its own initial count
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = COUNT_TOP;
        2: v = 16'd1;
        3: v = COUNT_W'($urandom_range(0, 5));
        4: v = COUNT_TOP - COUNT_W'($urandom_range(0, 3));
        default: v = COUNT_W'($urandom);
      endcase
      if (phase == 0) v = '0;
      write_count(v);
      quiet = ($urandom_range(0, 4) == 0);
      shape = $urandom_range(0, 9);
      if (phase == 0 || shape < 7) begin
        // open, a run of operations, then mostly a close
        send_item(CMD_OPEN, TID_W'($urandom_range(0, 255)), 0, '0);
        len = $urandom_range(8, 40);
        for (int k = 0; k < len; k++) begin
          op = $urandom_range(0, 99);
          if (phase == 0 && k == 0) op = 99;
          if (op >= 96) begin
            // flood of waits, enough to hit a full queue
            burst = $urandom_range(17, 20);
            for (int b = 0; b < burst; b++)
              send_item(CMD_WAIT, TID_W'($urandom_range(0, 255)), 0, '0);
          end else if (op >= 93) begin
            wait_idle();
          end else if (op < 40) begin
            send_item(CMD_WAIT, TID_W'($urandom_range(0, 255)), 0, '0);
          end else if (op < 70) begin
            send_item(CMD_SIGNAL, TID_W'($urandom_range(0, 255)), 0, '0);
          end else if (op < 88) begin
            send_item(CMD_TRY_WAIT, TID_W'($urandom_range(0, 255)), 0, '0);
          end else begin
            send_item(CMD_W'($urandom_range(0, 7)), TID_W'($urandom_range(0, 255)), 0, '0);
          end
        end
        if (phase == 1) wait_idle();
        if (phase == 0 || $urandom_range(0, 4) != 0)
          send_item(CMD_CLOSE, TID_W'($urandom_range(0, 255)), 0, '0);
      end else begin
        // noise, any command code
        len = $urandom_range(10, 30);
        for (int k = 0; k < len; k++)
          send_item(CMD_W'($urandom_range(0, 7)), TID_W'($urandom_range(0, 255)), 0, '0);
      end
      phase++;
    end

    quiet = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/csq_pkg.sv
rtl/core/csq_ctrl.sv
rtl/core/csq_dpath.sv
rtl/core/counting_semaphore_wait_queue_unit.sv
tb/counting_semaphore_wait_queue_unit_test.sv
